// ----- rtl/lmlt_pkg.sv -----
// shared types and timing constants for the lcd mode line timing block
package lmlt_pkg;

  typedef enum logic [1:0] {
    MODE_HORIZ_BLANK = 2'd0,
    MODE_VERT_BLANK  = 2'd1,
    MODE_SEARCH      = 2'd2,
    MODE_TRANSFER    = 2'd3
  } mode_t;

  localparam int ACCUM_W = 10;
  localparam int LINE_W  = 8;
  localparam int TICK_W  = 8;

  localparam logic [ACCUM_W-1:0] TICKS_SEARCH   = 10'd80;
  localparam logic [ACCUM_W-1:0] TICKS_TRANSFER = 10'd172;
  localparam logic [ACCUM_W-1:0] TICKS_HBLANK   = 10'd204;
  localparam logic [ACCUM_W-1:0] TICKS_VLINE    = 10'd456;
  localparam logic [LINE_W-1:0]  LAST_VISIBLE   = 8'd144;
  localparam logic [LINE_W-1:0]  WRAP_LINE      = 8'd153;

  typedef struct packed {
    mode_t               mode;
    logic [ACCUM_W-1:0]  accum;
    logic [LINE_W-1:0]   line;
  } seq_state_t;

  typedef struct packed {
    logic [1:0]          mode;
    logic [LINE_W-1:0]   line;
    logic                line_written;
    logic                frame_render;
  } result_t;

endpackage

// ----- rtl/lmlt_if.sv -----
// valid/ready channel interfaces for tick items and mode results
interface lmlt_in_if;
  logic                      valid;
  logic                      ready;
  logic [lmlt_pkg::TICK_W-1:0] tick_count;
  logic                      render_enable;

  modport source (output valid, output tick_count, output render_enable, input ready);
  modport sink   (input valid, input tick_count, input render_enable, output ready);
endinterface

interface lmlt_out_if;
  logic                      valid;
  logic                      ready;
  logic [1:0]                mode;
  logic [lmlt_pkg::LINE_W-1:0] line;
  logic                      line_written;
  logic                      frame_render;

  modport source (output valid, output mode, output line, output line_written,
                  output frame_render, input ready);
  modport sink   (input valid, input mode, input line, input line_written,
                  input frame_render, output ready);
endinterface

// ----- rtl/lmlt_step.sv -----
// next-state and result logic for one tick transaction
module lmlt_step (
  input  lmlt_pkg::seq_state_t          state,
  input  logic [lmlt_pkg::TICK_W-1:0]   tick_count,
  input  logic                          render_enable,
  output lmlt_pkg::seq_state_t          state_next,
  output lmlt_pkg::result_t             result
);

  logic [lmlt_pkg::ACCUM_W-1:0] sum;
  logic [lmlt_pkg::LINE_W-1:0]  line_inc;
  logic                         done;
  logic                         wrote;
  logic                         frame;

  assign sum      = state.accum + {{(lmlt_pkg::ACCUM_W-lmlt_pkg::TICK_W){1'b0}}, tick_count};
  assign line_inc = state.line + 8'd1;

  // threshold reached for the current mode
  always_comb begin
    case (state.mode)
      lmlt_pkg::MODE_SEARCH:      done = (sum >= lmlt_pkg::TICKS_SEARCH);
      lmlt_pkg::MODE_TRANSFER:    done = (sum >= lmlt_pkg::TICKS_TRANSFER);
      lmlt_pkg::MODE_HORIZ_BLANK: done = (sum >= lmlt_pkg::TICKS_HBLANK);
      default:                    done = (sum >= lmlt_pkg::TICKS_VLINE);
    endcase
  end

  // next state
  always_comb begin
    state_next       = state;
    state_next.accum = sum;
    if (done) begin
      state_next.accum = '0;
      case (state.mode)
        lmlt_pkg::MODE_SEARCH: begin
          state_next.mode = lmlt_pkg::MODE_TRANSFER;
        end
        lmlt_pkg::MODE_TRANSFER: begin
          state_next.mode = lmlt_pkg::MODE_HORIZ_BLANK;
          state_next.line = line_inc;
        end
        lmlt_pkg::MODE_HORIZ_BLANK: begin
          state_next.mode = (state.line == lmlt_pkg::LAST_VISIBLE) ?
                            lmlt_pkg::MODE_VERT_BLANK : lmlt_pkg::MODE_SEARCH;
        end
        default: begin
          if (line_inc == lmlt_pkg::WRAP_LINE) begin
            state_next.line = '0;
            state_next.mode = lmlt_pkg::MODE_SEARCH;
          end else begin
            state_next.line = line_inc;
          end
        end
      endcase
    end
  end

  // flags
  always_comb begin
    wrote = 1'b0;
    frame = 1'b0;
    case (state.mode)
      lmlt_pkg::MODE_TRANSFER: wrote = done;
      lmlt_pkg::MODE_VERT_BLANK: begin
        wrote = done;
        frame = done && (line_inc == lmlt_pkg::WRAP_LINE) && render_enable;
      end
      default: begin
        wrote = 1'b0;
        frame = 1'b0;
      end
    endcase
  end

  assign result.mode         = state_next.mode;
  assign result.line         = state_next.line;
  assign result.line_written = wrote;
  assign result.frame_render = frame;

endmodule

// ----- rtl/lmlt_out_reg.sv -----
// result register that holds a finished transaction until it is taken
module lmlt_out_reg (
  input  logic                clk,
  input  logic                rst,
  input  logic                load,
  input  lmlt_pkg::result_t   data,
  output logic                can_load,
  lmlt_out_if.source          out_item
);

  logic              valid;
  lmlt_pkg::result_t held;

  // free when empty or being drained this cycle
  assign can_load = !valid || out_item.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (load) begin
      valid <= 1'b1;
    end else if (out_item.ready) begin
      valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      held <= data;
    end
  end

  assign out_item.valid        = valid;
  assign out_item.mode         = held.mode;
  assign out_item.line         = held.line;
  assign out_item.line_written = held.line_written;
  assign out_item.frame_render = held.frame_render;

endmodule

// ----- rtl/lcd_mode_line_timing.sv -----
// top level of the lcd mode line timing sequencer
// Takes one tick transaction per cycle when the result register can load, and
// returns one result per transaction from it. The step from state and tick count
// to next state is a single 10-bit add, a threshold compare and a line increment,
// so a new item is taken every cycle whenever the result register is empty or
// being drained at the same edge. Mode, tick accumulator and line are updated at
// the accepting edge; excess ticks at a mode change are dropped.
module lcd_mode_line_timing (
  input  logic          clk,
  input  logic          rst,
  lmlt_in_if.sink       in_item,
  lmlt_out_if.source    out_item
);

  lmlt_pkg::seq_state_t state;
  lmlt_pkg::seq_state_t state_next;
  lmlt_pkg::result_t    result;
  logic                 can_load;
  logic                 accept;

  assign in_item.ready = can_load;
  assign accept        = in_item.valid && can_load;

  lmlt_step u_step (
    .state         (state),
    .tick_count    (in_item.tick_count),
    .render_enable (in_item.render_enable),
    .state_next    (state_next),
    .result        (result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state.mode  <= lmlt_pkg::MODE_SEARCH;
      state.accum <= '0;
      state.line  <= '0;
    end else if (accept) begin
      state <= state_next;
    end
  end

  lmlt_out_reg u_out_reg (
    .clk      (clk),
    .rst      (rst),
    .load     (accept),
    .data     (result),
    .can_load (can_load),
    .out_item (out_item)
  );

endmodule
